// ----- rtl/core/rdpt_pkg.sv -----
// Shared constants and register index codes for the rectangular dipole transport block.
// No dependencies.
package rdpt_pkg;

    localparam int FIELD_W   = 32;
    localparam int LEN_W     = 31;
    localparam int CFG_IDX_W = 4;

    // Reset value of cos_a: 1.0 in Q8.24
    localparam logic [FIELD_W-1:0] COS_A_RESET = 32'd16777216;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_A           = 4'd0,
        REG_SIN_A           = 4'd1,
        REG_R_SIN           = 4'd2,
        REG_R_ONE_MINUS_COS = 4'd3,
        REG_SIN_OVER_R      = 4'd4,
        REG_TAN_HALF_OVER_R = 4'd5,
        REG_MAGNET_LENGTH   = 4'd6,
        REG_DL_DP_COEFF     = 4'd7
    } cfg_reg_t;

endpackage

// ----- rtl/core/rect_dipole_particle_transport.sv -----
// Rectangular dipole transfer map: entrance kick, linear dipole map, exit kick.
// Depends on rdpt_pkg. Six-stage pipeline, one particle per beat.
// Throughput: one particle per cycle while the output is not stalled; the three multiplier
// stages (entrance kick, dipole map, exit kick) are each one register stage deep.
// A stalled output freezes the whole pipeline; input stall follows it.
// Reset clears all valid bits and loads the coefficient registers with their defaults.
module rect_dipole_particle_transport #(
    parameter int FRAC_BITS  = 24,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_wr_en,
    input  logic [rdpt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rdpt_pkg::FIELD_W-1:0]          cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [rdpt_pkg::FIELD_W-1:0]   pos_x,
    input  logic signed [rdpt_pkg::FIELD_W-1:0]   slope_x,
    input  logic signed [rdpt_pkg::FIELD_W-1:0]   pos_y,
    input  logic signed [rdpt_pkg::FIELD_W-1:0]   slope_y,
    input  logic signed [rdpt_pkg::FIELD_W-1:0]   mom_dev,
    input  logic signed [rdpt_pkg::FIELD_W-1:0]   path_dev,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [rdpt_pkg::FIELD_W-1:0]   out_x,
    output logic signed [rdpt_pkg::FIELD_W-1:0]   out_slope_x,
    output logic signed [rdpt_pkg::FIELD_W-1:0]   out_y,
    output logic signed [rdpt_pkg::FIELD_W-1:0]   out_slope_y,
    output logic signed [rdpt_pkg::FIELD_W-1:0]   out_path
);

    localparam int FW    = rdpt_pkg::FIELD_W;
    localparam int SAT_W = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    // shifted product width, and sum width for up to three terms
    localparam int PW    = 2 * FW - FRAC_BITS;
    localparam int SW    = PW + 2;
    localparam logic signed [SW-1:0] SAT_HI = SW'((longint'(1) <<< (SAT_W - 1)) - 1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    function automatic logic signed [PW-1:0] fmul(input logic signed [FW-1:0] a,
                                                 input logic signed [FW-1:0] b);
        logic signed [2*FW-1:0] full;
        full = a * b;
        return PW'(full >>> FRAC_BITS);
    endfunction

    function automatic logic signed [FW-1:0] sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] c;
        if (v > SAT_HI)
            c = SAT_HI;
        else if (v < SAT_LO)
            c = SAT_LO;
        else
            c = v;
        return FW'(c);
    endfunction

    // ---------------- coefficient registers ----------------
    logic signed [FW-1:0] cos_a_reg, sin_a_reg, r_sin_reg, r1c_reg;
    logic signed [FW-1:0] sor_reg, k_reg, dlc_reg;
    logic [rdpt_pkg::LEN_W-1:0] len_reg;
    logic signed [FW-1:0] len_s;
    logic                 drift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_a_reg <= rdpt_pkg::COS_A_RESET;
            sin_a_reg <= '0;
            r_sin_reg <= '0;
            r1c_reg   <= '0;
            sor_reg   <= '0;
            k_reg     <= '0;
            len_reg   <= '0;
            dlc_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rdpt_pkg::REG_COS_A:           cos_a_reg <= cfg_data;
                rdpt_pkg::REG_SIN_A:           sin_a_reg <= cfg_data;
                rdpt_pkg::REG_R_SIN:           r_sin_reg <= cfg_data;
                rdpt_pkg::REG_R_ONE_MINUS_COS: r1c_reg   <= cfg_data;
                rdpt_pkg::REG_SIN_OVER_R:      sor_reg   <= cfg_data;
                rdpt_pkg::REG_TAN_HALF_OVER_R: k_reg     <= cfg_data;
                rdpt_pkg::REG_MAGNET_LENGTH:   len_reg   <= cfg_data[rdpt_pkg::LEN_W-1:0];
                rdpt_pkg::REG_DL_DP_COEFF:     dlc_reg   <= cfg_data;
                default:                       ;
            endcase
        end
    end

    assign len_s = signed'({1'b0, len_reg});
    assign drift = (k_reg == '0) && (sor_reg == '0);

    // ---------------- pipeline control ----------------
    logic       adv;
    logic [5:0] vld_reg;

    assign adv      = !vld_reg[5] || !out_stall;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[4:0], in_valid};
    end

    // ---------------- stage 1: entrance kick, drift and dp/x products ----------------
    logic signed [FW-1:0] s1_x_reg, s1_dx_reg, s1_y_reg, s1_dy_reg, s1_pl_reg;
    logic signed [PW-1:0] s1_kx_reg, s1_ky_reg, s1_ldx_reg, s1_ldy_reg;
    logic signed [PW-1:0] s1_cax_reg, s1_r1cdp_reg, s1_sorx_reg;
    logic signed [PW-1:0] s1_sadp_reg, s1_sax_reg, s1_dlcdp_reg;
    logic                 s1_drift_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg     <= pos_x;
            s1_dx_reg    <= slope_x;
            s1_y_reg     <= pos_y;
            s1_dy_reg    <= slope_y;
            s1_pl_reg    <= path_dev;
            s1_drift_reg <= drift;
            s1_kx_reg    <= fmul(k_reg, pos_x);
            s1_ky_reg    <= fmul(k_reg, pos_y);
            s1_ldx_reg   <= fmul(len_s, slope_x);
            s1_ldy_reg   <= fmul(len_s, slope_y);
            s1_cax_reg   <= fmul(cos_a_reg, pos_x);
            s1_r1cdp_reg <= fmul(r1c_reg, mom_dev);
            s1_sorx_reg  <= fmul(sor_reg, pos_x);
            s1_sadp_reg  <= fmul(sin_a_reg, mom_dev);
            s1_sax_reg   <= fmul(sin_a_reg, pos_x);
            s1_dlcdp_reg <= fmul(dlc_reg, mom_dev);
        end
    end

    // ---------------- stage 2: kicked slopes, drift results, partial sums ----------------
    logic signed [FW-1:0] s2_dx1_reg, s2_dy1_reg, s2_y_reg, s2_ox_reg, s2_oy_reg;
    logic signed [FW-1:0] s2_dx_reg, s2_pl_reg;
    logic signed [SW-1:0] s2_ax_reg, s2_adx_reg, s2_adl_reg;
    logic                 s2_drift_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_dx1_reg   <= sat(SW'(s1_dx_reg) + SW'(s1_kx_reg));
            s2_dy1_reg   <= sat(SW'(s1_dy_reg) - SW'(s1_ky_reg));
            s2_ox_reg    <= sat(SW'(s1_x_reg) + SW'(s1_ldx_reg));
            s2_oy_reg    <= sat(SW'(s1_y_reg) + SW'(s1_ldy_reg));
            s2_y_reg     <= s1_y_reg;
            s2_dx_reg    <= s1_dx_reg;
            s2_pl_reg    <= s1_pl_reg;
            s2_ax_reg    <= SW'(s1_cax_reg) + SW'(s1_r1cdp_reg);
            s2_adx_reg   <= SW'(s1_sadp_reg) - SW'(s1_sorx_reg);
            s2_adl_reg   <= -SW'(s1_sax_reg) - SW'(s1_dlcdp_reg);
            s2_drift_reg <= s1_drift_reg;
        end
    end

    // ---------------- stage 3: dipole map products on kicked slopes ----------------
    logic signed [PW-1:0] s3_rsdx1_reg, s3_cadx1_reg, s3_r1cdx1_reg, s3_ldy1_reg;
    logic signed [SW-1:0] s3_ax_reg, s3_adx_reg, s3_adl_reg;
    logic signed [FW-1:0] s3_dy1_reg, s3_y_reg, s3_ox_reg, s3_oy_reg, s3_dx_reg, s3_pl_reg;
    logic                 s3_drift_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_rsdx1_reg  <= fmul(r_sin_reg, s2_dx1_reg);
            s3_cadx1_reg  <= fmul(cos_a_reg, s2_dx1_reg);
            s3_r1cdx1_reg <= fmul(r1c_reg, s2_dx1_reg);
            s3_ldy1_reg   <= fmul(len_s, s2_dy1_reg);
            s3_ax_reg     <= s2_ax_reg;
            s3_adx_reg    <= s2_adx_reg;
            s3_adl_reg    <= s2_adl_reg;
            // k is zero in drift, so dy1 is slope_y unchanged
            s3_dy1_reg    <= s2_dy1_reg;
            s3_y_reg      <= s2_y_reg;
            s3_ox_reg     <= s2_ox_reg;
            s3_oy_reg     <= s2_oy_reg;
            s3_dx_reg     <= s2_dx_reg;
            s3_pl_reg     <= s2_pl_reg;
            s3_drift_reg  <= s2_drift_reg;
        end
    end

    // ---------------- stage 4: dipole map sums ----------------
    logic signed [FW-1:0] s4_x2_reg, s4_dx2_reg, s4_y2_reg, s4_dl_reg, s4_dy1_reg;
    logic                 s4_drift_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_x2_reg    <= s3_drift_reg ? s3_ox_reg : sat(s3_ax_reg + SW'(s3_rsdx1_reg));
            s4_dx2_reg   <= s3_drift_reg ? s3_dx_reg : sat(s3_adx_reg + SW'(s3_cadx1_reg));
            s4_y2_reg    <= s3_drift_reg ? s3_oy_reg
                                         : sat(SW'(s3_y_reg) + SW'(s3_ldy1_reg));
            s4_dl_reg    <= s3_drift_reg ? s3_pl_reg : sat(s3_adl_reg - SW'(s3_r1cdx1_reg));
            s4_dy1_reg   <= s3_dy1_reg;
            s4_drift_reg <= s3_drift_reg;
        end
    end

    // ---------------- stage 5: exit kick products ----------------
    logic signed [PW-1:0] s5_kx2_reg, s5_ky2_reg;
    logic signed [FW-1:0] s5_x2_reg, s5_dx2_reg, s5_y2_reg, s5_dl_reg, s5_dy1_reg;
    logic                 s5_drift_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_kx2_reg   <= fmul(k_reg, s4_x2_reg);
            s5_ky2_reg   <= fmul(k_reg, s4_y2_reg);
            s5_x2_reg    <= s4_x2_reg;
            s5_dx2_reg   <= s4_dx2_reg;
            s5_y2_reg    <= s4_y2_reg;
            s5_dl_reg    <= s4_dl_reg;
            s5_dy1_reg   <= s4_dy1_reg;
            s5_drift_reg <= s4_drift_reg;
        end
    end

    // ---------------- stage 6: exit kick sums, output register ----------------
    logic signed [FW-1:0] odx_next, ody_next;

    always_comb
    begin
        if (s5_drift_reg)
        begin
            odx_next = s5_dx2_reg;
            ody_next = s5_dy1_reg;
        end
        else
        begin
            odx_next = sat(SW'(s5_dx2_reg) + SW'(s5_kx2_reg));
            ody_next = sat(SW'(s5_dy1_reg) - SW'(s5_ky2_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x       <= s5_x2_reg;
            out_slope_x <= odx_next;
            out_y       <= s5_y2_reg;
            out_slope_y <= ody_next;
            out_path    <= s5_dl_reg;
        end
    end

    assign out_valid = vld_reg[5];

    // ---------------- assertions ----------------
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted beat did not enter stage 1");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");

    a_shift_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (vld_reg[5:1] == $past(vld_reg[4:0])))
        else $error("valid bits did not shift when the pipeline advanced");

    a_drift_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[4] && s4_drift_reg) |=> s5_drift_reg)
        else $error("drift flag lost between stages 4 and 5");

endmodule
